FILE: hdl/rmq_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Holds item types, derived widths and the side payload carried down the pipeline.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = DATA_WIDTH - 2;
  localparam int MAG_W      = DATA_WIDTH + 1;
  localparam int CMP_W      = DATA_WIDTH + 2;
  localparam int PSH_W      = $clog2(MAG_W);
  localparam int NRM_W      = 30;
  localparam int SUM_W      = 2 * NRM_W + 2;
  localparam int XW         = SUM_W + 2;
  localparam int SQ_STAGES  = SUM_W / 2;
  localparam int ROOT_W     = NRM_W + 1;
  localparam int QUO_W      = FRAC + 1;
  localparam int DIV_W      = NRM_W + FRAC + 1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m_xx;
    logic signed [DATA_WIDTH-1:0] m_xy;
    logic signed [DATA_WIDTH-1:0] m_xz;
    logic signed [DATA_WIDTH-1:0] m_yx;
    logic signed [DATA_WIDTH-1:0] m_yy;
    logic signed [DATA_WIDTH-1:0] m_yz;
    logic signed [DATA_WIDTH-1:0] m_zx;
    logic signed [DATA_WIDTH-1:0] m_zy;
    logic signed [DATA_WIDTH-1:0] m_zz;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] q_scalar;
    logic signed [DATA_WIDTH-1:0] q_x;
    logic signed [DATA_WIDTH-1:0] q_y;
    logic signed [DATA_WIDTH-1:0] q_z;
    logic [1:0]                   branch_used;
    logic                         degenerate;
  } out_item_t;

  typedef struct packed {
    logic [3:0][NRM_W-1:0] mag;
    logic [3:0]            neg;
    logic [1:0]            idx;
    logic                  degen;
  } side_t;

endpackage

FILE: hdl/rmq_front.sv
// Front end: traces, branch pick, components, normalization and sum of squares.
// Six register stages. Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  rmq_pkg::in_item_t    in_item,
  output logic                 x_vld,
  output logic [rmq_pkg::SUM_W-1:0] x_sum,
  output rmq_pkg::side_t       x_side
);
  import rmq_pkg::*;

  logic [5:0] v_r;

  in_item_t s1_r;

  logic signed [CMP_W-1:0] e_xx, e_xy, e_xz, e_yx, e_yy, e_yz, e_zx, e_zy, e_zz;
  logic signed [CMP_W-1:0] tr0, tr1, tr2, tr3, one_c;
  logic signed [CMP_W-1:0] c_nxt [4];
  logic [1:0]              idx_nxt;
  logic [3:0][MAG_W-1:0]   mag_nxt;
  logic [3:0]              neg_nxt;

  logic [3:0][MAG_W-1:0]   mag2_r;
  logic [3:0]              neg2_r;
  logic [1:0]              idx2_r;

  logic [MAG_W-1:0]        mx;
  logic [PSH_W-1:0]        pos_nxt;
  logic [3:0][MAG_W-1:0]   mag3_r;
  logic [3:0]              neg3_r;
  logic [1:0]              idx3_r;
  logic [PSH_W-1:0]        pos3_r;
  logic                    degen3_r;

  side_t                   side4_nxt;
  side_t                   side4_r;
  logic [3:0][2*NRM_W-1:0] sq5_r;
  side_t                   side5_r;
  logic [SUM_W-1:0]        sum6_r;
  side_t                   side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  always_comb begin
    one_c = CMP_W'(1) <<< FRAC;
    e_xx = CMP_W'(s1_r.m_xx);
    e_xy = CMP_W'(s1_r.m_xy);
    e_xz = CMP_W'(s1_r.m_xz);
    e_yx = CMP_W'(s1_r.m_yx);
    e_yy = CMP_W'(s1_r.m_yy);
    e_yz = CMP_W'(s1_r.m_yz);
    e_zx = CMP_W'(s1_r.m_zx);
    e_zy = CMP_W'(s1_r.m_zy);
    e_zz = CMP_W'(s1_r.m_zz);
    tr0 = one_c + e_xx + e_yy + e_zz;
    tr1 = one_c + e_xx - e_yy - e_zz;
    tr2 = one_c - e_xx + e_yy - e_zz;
    tr3 = one_c - e_xx - e_yy + e_zz;
    idx_nxt = 2'd0;
    if (tr1 > tr0) idx_nxt = 2'd1;
    if (tr2 > ((idx_nxt == 2'd1) ? tr1 : tr0)) idx_nxt = 2'd2;
    if (tr3 > ((idx_nxt == 2'd2) ? tr2 : (idx_nxt == 2'd1) ? tr1 : tr0)) idx_nxt = 2'd3;
    case (idx_nxt)
      2'd0: begin
        c_nxt[0] = tr0;         c_nxt[1] = e_yz - e_zy;
        c_nxt[2] = e_zx - e_xz; c_nxt[3] = e_xy - e_yx;
      end
      2'd1: begin
        c_nxt[0] = e_yz - e_zy; c_nxt[1] = tr1;
        c_nxt[2] = e_xy + e_yx; c_nxt[3] = e_zx + e_xz;
      end
      2'd2: begin
        c_nxt[0] = e_zx - e_xz; c_nxt[1] = e_xy + e_yx;
        c_nxt[2] = tr2;         c_nxt[3] = e_yz + e_zy;
      end
      default: begin
        c_nxt[0] = e_xy - e_yx; c_nxt[1] = e_zx + e_xz;
        c_nxt[2] = e_yz + e_zy; c_nxt[3] = tr3;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      neg_nxt[i] = c_nxt[i][CMP_W-1];
      mag_nxt[i] = neg_nxt[i] ? MAG_W'(-c_nxt[i]) : MAG_W'(c_nxt[i]);
    end
  end

  always_comb begin
    mx = mag2_r[0];
    for (int i = 1; i < 4; i++) begin
      if (mag2_r[i] > mx) mx = mag2_r[i];
    end
    pos_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx[b]) pos_nxt = PSH_W'(b);
    end
  end

  // place the largest magnitude's top bit at bit NRM_W-1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side4_nxt.mag[i] = NRM_W'({mag3_r[i], {(NRM_W-1){1'b0}}} >> pos3_r);
    end
    side4_nxt.neg   = neg3_r;
    side4_nxt.idx   = idx3_r;
    side4_nxt.degen = degen3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= in_item;
      mag2_r   <= mag_nxt;
      neg2_r   <= neg_nxt;
      idx2_r   <= idx_nxt;
      mag3_r   <= mag2_r;
      neg3_r   <= neg2_r;
      idx3_r   <= idx2_r;
      pos3_r   <= pos_nxt;
      degen3_r <= (mx == '0);
      side4_r  <= side4_nxt;
      for (int i = 0; i < 4; i++) begin
        sq5_r[i] <= side4_r.mag[i] * side4_r.mag[i];
      end
      side5_r  <= side4_r;
      sum6_r   <= (SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1])) + (SUM_W'(sq5_r[2]) + SUM_W'(sq5_r[3]));
      side6_r  <= side5_r;
    end
  end

  assign x_vld  = v_r[5];
  assign x_sum  = sum6_r;
  assign x_side = side6_r;

endmodule

FILE: hdl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries the side payload alongside. Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       x_vld,
  input  logic [rmq_pkg::SUM_W-1:0]  x_sum,
  input  rmq_pkg::side_t             x_side,
  output logic                       r_vld,
  output logic [rmq_pkg::ROOT_W-1:0] r_root,
  output rmq_pkg::side_t             r_side
);
  import rmq_pkg::*;

  logic          v_r    [SQ_STAGES];
  logic [XW-1:0] x_r    [SQ_STAGES];
  logic [XW-1:0] res_r  [SQ_STAGES];
  side_t         side_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    localparam logic [XW-1:0] BIT = XW'(1) << (SUM_W - 2 - 2 * k);
    logic          vi;
    logic [XW-1:0] xi;
    logic [XW-1:0] ri;
    logic [XW-1:0] trial;
    side_t         si;
    if (k == 0) begin : g_in
      assign vi = x_vld;
      assign xi = XW'(x_sum);
      assign ri = '0;
      assign si = x_side;
    end else begin : g_mid
      assign vi = v_r[k-1];
      assign xi = x_r[k-1];
      assign ri = res_r[k-1];
      assign si = side_r[k-1];
    end
    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          x_r[k]   <= xi - trial;
          res_r[k] <= (ri >> 1) + BIT;
        end else begin
          x_r[k]   <= xi;
          res_r[k] <= ri >> 1;
        end
        side_r[k] <= si;
      end
    end
  end

  assign r_vld  = v_r[SQ_STAGES-1];
  assign r_root = res_r[SQ_STAGES-1][ROOT_W-1:0];
  assign r_side = side_r[SQ_STAGES-1];

endmodule

FILE: hdl/rmq_div.sv
// Four-lane pipelined rounding divider, one quotient bit per stage.
// Divides each normalized magnitude by the root. Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       r_vld,
  input  logic [rmq_pkg::ROOT_W-1:0] r_root,
  input  rmq_pkg::side_t             r_side,
  output logic                       q_vld,
  output logic [3:0][rmq_pkg::QUO_W-1:0] q_mag,
  output rmq_pkg::side_t             q_side
);
  import rmq_pkg::*;

  logic                   v0_r;
  logic [3:0][DIV_W-1:0]  rem0_r;
  logic [ROOT_W-1:0]      root0_r;
  side_t                  side0_r;

  logic                   v_r    [QUO_W];
  logic [3:0][DIV_W-1:0]  rem_r  [QUO_W];
  logic [3:0][QUO_W-1:0]  quo_r  [QUO_W];
  logic [ROOT_W-1:0]      root_r [QUO_W];
  side_t                  side_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        rem0_r[i] <= DIV_W'({r_side.mag[i], {FRAC{1'b0}}}) + DIV_W'(r_root >> 1);
      end
      root0_r <= r_root;
      side0_r <= r_side;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    localparam int SH = QUO_W - 1 - k;
    logic                  vi;
    logic [3:0][DIV_W-1:0] remi;
    logic [3:0][QUO_W-1:0] quoi;
    logic [ROOT_W-1:0]     rooti;
    side_t                 si;
    logic [DIV_W-1:0]      dsr;
    if (k == 0) begin : g_in
      assign vi    = v0_r;
      assign remi  = rem0_r;
      assign quoi  = '0;
      assign rooti = root0_r;
      assign si    = side0_r;
    end else begin : g_mid
      assign vi    = v_r[k-1];
      assign remi  = rem_r[k-1];
      assign quoi  = quo_r[k-1];
      assign rooti = root_r[k-1];
      assign si    = side_r[k-1];
    end
    assign dsr = DIV_W'(rooti) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          if (remi[i] >= dsr) begin
            rem_r[k][i]     <= remi[i] - dsr;
            quo_r[k][i]     <= quoi[i] | (QUO_W'(1) << SH);
          end else begin
            rem_r[k][i]     <= remi[i];
            quo_r[k][i]     <= quoi[i];
          end
        end
        root_r[k] <= rooti;
        side_r[k] <= si;
      end
    end
  end

  assign q_vld  = v_r[QUO_W-1];
  assign q_mag  = quo_r[QUO_W-1];
  assign q_side = side_r[QUO_W-1];

endmodule

FILE: hdl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion converter, top level.
// Instantiates rmq_front, rmq_sqrt and rmq_div; depends on rmq_pkg.
//
// Takes one 3x3 direction cosine matrix per cycle and returns one unit quaternion per item,
// with the chosen trace branch and a zero-norm flag. Fully pipelined: one item per cycle,
// passing through six front stages, the bit-per-stage square root, the bit-per-stage
// divider and an output register. A stall at the output holds the whole pipeline;
// in_ready follows out_ready combinationally.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rmq_pkg::out_item_t  out_item
);
  import rmq_pkg::*;

  logic                  en;
  logic                  x_vld;
  logic [SUM_W-1:0]      x_sum;
  side_t                 x_side;
  logic                  r_vld;
  logic [ROOT_W-1:0]     r_root;
  side_t                 r_side;
  logic                  q_vld;
  logic [3:0][QUO_W-1:0] q_mag;
  side_t                 q_side;

  logic                  out_valid_r;
  out_item_t             out_item_r;
  out_item_t             out_item_nxt;
  logic signed [DATA_WIDTH-1:0] qv [4];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rmq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_item (in_item),
    .x_vld   (x_vld),
    .x_sum   (x_sum),
    .x_side  (x_side)
  );

  rmq_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .x_vld  (x_vld),
    .x_sum  (x_sum),
    .x_side (x_side),
    .r_vld  (r_vld),
    .r_root (r_root),
    .r_side (r_side)
  );

  rmq_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .r_vld  (r_vld),
    .r_root (r_root),
    .r_side (r_side),
    .q_vld  (q_vld),
    .q_mag  (q_mag),
    .q_side (q_side)
  );

  // apply sign, force zero on a degenerate item
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qv[i] = DATA_WIDTH'(q_mag[i]);
      if (q_side.neg[i]) qv[i] = -qv[i];
      if (q_side.degen) qv[i] = '0;
    end
    out_item_nxt.q_scalar    = qv[0];
    out_item_nxt.q_x         = qv[1];
    out_item_nxt.q_y         = qv[2];
    out_item_nxt.q_z         = qv[3];
    out_item_nxt.branch_used = q_side.idx;
    out_item_nxt.degenerate  = q_side.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |->
      out_item.q_scalar == '0 && out_item.q_x == '0 &&
      out_item.q_y == '0 && out_item.q_z == '0)
    else $error("degenerate item with nonzero quaternion");

  a_branch_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_item.branch_used == 2'd0 && !out_item.q_scalar[DATA_WIDTH-1]) ||
      (out_item.branch_used == 2'd1 && !out_item.q_x[DATA_WIDTH-1]) ||
      (out_item.branch_used == 2'd2 && !out_item.q_y[DATA_WIDTH-1]) ||
      (out_item.branch_used == 2'd3 && !out_item.q_z[DATA_WIDTH-1]))
    else $error("chosen branch component is negative");

endmodule
